// ===== hw/rtl/lav_pkg.sv =====
// Package for the look-at view matrix block: register indexes, pipeline depths
// and the shared fixed-point helpers. Depends on nothing.
package lav_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_UP_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_Z = 2'd2;

  localparam logic [31:0] UP_X_RESET = 32'd0;
  localparam logic [31:0] UP_Y_RESET = 32'd65536;
  localparam logic [31:0] UP_Z_RESET = 32'd0;

  // Normalizer depth: five front stages, the sum stage, one stage per root bit,
  // the dividend stage, one stage per quotient bit and the sign stage.
  localparam int NORM_PRE   = 6;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  localparam int NORM_LAT   = NORM_PRE + SQRT_STEPS + DIV_STEPS + 2;

  function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return a * b;
  endfunction

  // Round a value in units of 2^-30 to nearest, halves away from zero.
  function automatic logic signed [63:0] round30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    q = (mag + 64'd536870912) >> 30;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== hw/rtl/lav_ifs.sv =====
// Channel interfaces of the look-at view matrix block: input, result and
// configuration write. Depends on nothing.
interface lav_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                output ready);
endinterface

interface lav_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] side_x;
  logic signed [31:0] side_y;
  logic signed [31:0] side_z;
  logic signed [31:0] upright_x;
  logic signed [31:0] upright_y;
  logic signed [31:0] upright_z;
  logic signed [31:0] back_x;
  logic signed [31:0] back_y;
  logic signed [31:0] back_z;
  logic signed [31:0] shift_x;
  logic signed [31:0] shift_y;
  logic signed [31:0] shift_z;
  modport source (output valid, side_x, side_y, side_z, upright_x, upright_y,
                  upright_z, back_x, back_y, back_z, shift_x, shift_y, shift_z,
                  input ready);
  modport sink (input valid, side_x, side_y, side_z, upright_x, upright_y,
                upright_z, back_x, back_y, back_z, shift_x, shift_y, shift_z,
                output ready);
endinterface

interface lav_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/lav_normalize.sv =====
// Pipelined 3-vector normalizer: magnitude scaling, bit-per-stage square root
// and bit-per-stage division to Q2.30. Depends on lav_pkg.
module lav_normalize (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [2:0][63:0] c_i,
  output logic             vld_o,
  output logic [2:0][31:0] o_o
);

  localparam int NSQ = lav_pkg::SQRT_STEPS;
  localparam int NDV = lav_pkg::DIV_STEPS;

  typedef struct packed {
    logic [63:0]      n;
    logic [63:0]      res;
    logic [2:0][29:0] m;
    logic [2:0]       sgn;
    logic             zero;
  } sq_t;

  typedef struct packed {
    logic [2:0][63:0] num;
    logic [2:0][31:0] q;
    logic [31:0]      len;
    logic [2:0]       sgn;
    logic             zero;
  } dv_t;

  function automatic logic [5:0] msb_pos(input logic [62:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 63; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  logic [4:0]       pv_q;
  logic [NSQ:0]     sqv_q;
  logic [NDV:0]     dvv_q;
  logic             ov_q;

  logic [2:0][62:0] m1_q, m2_q, m3_q;
  logic [2:0]       sg1_q, sg2_q, sg3_q, sg4_q, sg5_q;
  logic [62:0]      a2_q;
  logic [5:0]       p3_q;
  logic             z3_q, z4_q, z5_q;
  logic [2:0][29:0] m4_q, m5_q;
  logic [2:0][59:0] sqr5_q;
  logic [62:0]      a_max;
  logic [2:0][29:0] m_scaled;
  sq_t              sq_q [NSQ+1];
  dv_t              dv_q [NDV+1];
  logic [2:0][31:0] o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= '0;
      sqv_q <= '0;
      dvv_q <= '0;
      ov_q  <= 1'b0;
    end else if (en_i) begin
      pv_q  <= {pv_q[3:0], vld_i};
      sqv_q <= {sqv_q[NSQ-1:0], pv_q[4]};
      dvv_q <= {dvv_q[NDV-1:0], sqv_q[NSQ]};
      ov_q  <= dvv_q[NDV];
    end
  end

  always_comb begin
    a_max = m1_q[0];
    if (m1_q[1] > a_max) a_max = m1_q[1];
    if (m1_q[2] > a_max) a_max = m1_q[2];
  end

  // Common scaling brings the largest magnitude into [2^29, 2^30).
  always_comb begin
    logic [62:0] sh;
    for (int l = 0; l < 3; l++) begin
      if (p3_q >= 6'd29) begin
        sh = m3_q[l] >> (p3_q - 6'd29);
      end else begin
        sh = m3_q[l] << (6'd29 - p3_q);
      end
      m_scaled[l] = sh[29:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) begin
        m1_q[l]   <= c_i[l][63] ? 63'(-c_i[l]) : c_i[l][62:0];
        sg1_q[l]  <= c_i[l][63];
        sqr5_q[l] <= 60'(m4_q[l]) * 60'(m4_q[l]);
      end
      m2_q  <= m1_q;
      sg2_q <= sg1_q;
      a2_q  <= a_max;
      m3_q  <= m2_q;
      sg3_q <= sg2_q;
      p3_q  <= msb_pos(a2_q);
      z3_q  <= (a2_q == '0);
      m4_q  <= m_scaled;
      sg4_q <= sg3_q;
      z4_q  <= z3_q;
      m5_q  <= m4_q;
      sg5_q <= sg4_q;
      z5_q  <= z4_q;
      sq_q[0].n    <= 64'(sqr5_q[0]) + 64'(sqr5_q[1]) + 64'(sqr5_q[2]);
      sq_q[0].res  <= '0;
      sq_q[0].m    <= m5_q;
      sq_q[0].sgn  <= sg5_q;
      sq_q[0].zero <= z5_q;
      for (int l = 0; l < 3; l++) begin
        dv_q[0].num[l] <= {4'd0, sq_q[NSQ].m[l], 30'd0} + {33'd0, sq_q[NSQ].res[31:1]};
      end
      dv_q[0].q    <= '0;
      dv_q[0].len  <= sq_q[NSQ].res[31:0];
      dv_q[0].sgn  <= sq_q[NSQ].sgn;
      dv_q[0].zero <= sq_q[NSQ].zero;
      for (int l = 0; l < 3; l++) begin
        o_q[l] <= dv_q[NDV].zero ? 32'd0 :
                  (dv_q[NDV].sgn[l] ? 32'(-dv_q[NDV].q[l]) : dv_q[NDV].q[l]);
      end
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam logic [63:0] BitC = 64'd1 << (2 * (NSQ - 1 - j));
    sq_t         nx;
    logic [63:0] t;
    always_comb begin
      nx = sq_q[j];
      t  = sq_q[j].res + BitC;
      if (sq_q[j].n >= t) begin
        nx.n   = sq_q[j].n - t;
        nx.res = (sq_q[j].res >> 1) + BitC;
      end else begin
        nx.res = sq_q[j].res >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) sq_q[j+1] <= nx;
    end
  end

  // Restoring division, one quotient bit per stage in each lane.
  for (genvar j = 0; j < NDV; j++) begin : g_div
    localparam int Sh = NDV - 1 - j;
    dv_t         nx;
    logic [63:0] dsr;
    always_comb begin
      nx  = dv_q[j];
      dsr = {32'd0, dv_q[j].len} << Sh;
      for (int l = 0; l < 3; l++) begin
        if (dv_q[j].num[l] >= dsr) begin
          nx.num[l]   = dv_q[j].num[l] - dsr;
          nx.q[l][Sh] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) dv_q[j+1] <= nx;
    end
  end

  assign vld_o = ov_q;
  assign o_o   = o_q;

endmodule

// ===== hw/rtl/look_at_view_matrix.sv =====
// Top level of the right-handed look-at view matrix block.
// Depends on lav_pkg, the channel interfaces in lav_ifs and lav_normalize.
//
// Usage: an input transfer on in_i carries an eye position and a target point
// in signed Q16.16. A result transfer on out_o carries the side, upright and
// back rows in signed Q2.30 and the three translations in saturated Q16.16.
// The up vector lives in three registers written through cfg_i (index 0 to
// 2 for x, y, z); writes to index 3 are taken and ignored. Write it only while
// no item is in flight.
// The path from input transfer to result valid has one input stage, two
// 72-stage normalizers, two cross-product stages and four stages for the
// recomputed up vector and the translations. Throughput is one item per
// cycle while the side register is empty, carried by the square roots and
// dividers that resolve one bit per stage. When the receiver holds ready low,
// the waiting result moves into a side register and every stage freezes from
// the next cycle on; in_i.ready comes from that register alone. Once it is
// taken, the next result follows in the next cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the up vector with (0, 1.0, 0).
module look_at_view_matrix (
  input logic     clk_i,
  input logic     rst_ni,
  lav_in_if.sink  in_i,
  lav_out_if.source out_o,
  lav_cfg_if.sink cfg_i
);

  localparam int FDLY = 2 + lav_pkg::NORM_LAT;
  localparam int EDLY = 2 * lav_pkg::NORM_LAT + 2;

  logic             en;
  logic [2:0][31:0] up_q;

  logic             v0_q, vc1_q, vc2_q, vp1_q, vp2_q, vp3_q, vp4_q;
  logic [2:0][31:0] eye0_q;
  logic [2:0][63:0] d0_q;
  logic             vn1, vn2;
  logic [2:0][31:0] f1, s2;
  logic [5:0][63:0] pc1_q;
  logic [2:0][63:0] cr2_q;
  logic [2:0][31:0] fdly_q [FDLY];
  logic [2:0][31:0] edly_q [EDLY];

  logic [5:0][63:0] sf1_q;
  logic [2:0][63:0] se1_q, fe1_q;
  logic [2:0][31:0] s1_q, f1_q, e1_q;
  logic [2:0][31:0] s2_q, f2_q, e2_q, u2_q;
  logic [31:0]      shx2_q, shz2_q;
  logic [2:0][31:0] s3_q, f3_q, u3_q;
  logic [2:0][63:0] ue3_q;
  logic [31:0]      shx3_q, shz3_q;
  logic [2:0][31:0] s4_q, f4_q, u4_q;
  logic [31:0]      shx4_q, shy4_q, shz4_q;

  logic              skid_q;
  logic [11:0][31:0] skid_data_q;
  logic [11:0][31:0] res4;
  logic [11:0][31:0] out_data;

  // One enable for every stage: advance unless the side register holds a result.
  assign en          = !skid_q;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q[0] <= lav_pkg::UP_X_RESET;
      up_q[1] <= lav_pkg::UP_Y_RESET;
      up_q[2] <= lav_pkg::UP_Z_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        lav_pkg::REG_UP_X: up_q[0] <= cfg_i.data;
        lav_pkg::REG_UP_Y: up_q[1] <= cfg_i.data;
        lav_pkg::REG_UP_Z: up_q[2] <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      vc1_q <= 1'b0;
      vc2_q <= 1'b0;
      vp1_q <= 1'b0;
      vp2_q <= 1'b0;
      vp3_q <= 1'b0;
      vp4_q <= 1'b0;
    end else if (en) begin
      v0_q  <= in_i.valid;
      vc1_q <= vn1;
      vc2_q <= vc1_q;
      vp1_q <= vn2;
      vp2_q <= vp1_q;
      vp3_q <= vp2_q;
      vp4_q <= vp3_q;
    end
  end

  // Input stage: the difference target - eye is kept exact in 64 bits.
  always_ff @(posedge clk_i) begin
    if (en) begin
      eye0_q[0] <= in_i.eye_x;
      eye0_q[1] <= in_i.eye_y;
      eye0_q[2] <= in_i.eye_z;
      d0_q[0] <= 64'(in_i.target_x) - 64'(in_i.eye_x);
      d0_q[1] <= 64'(in_i.target_y) - 64'(in_i.eye_y);
      d0_q[2] <= 64'(in_i.target_z) - 64'(in_i.eye_z);
    end
  end

  lav_normalize u_norm_fwd (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (v0_q),
    .c_i   (d0_q),
    .vld_o (vn1),
    .o_o   (f1)
  );

  // Cross product f x up, exact in Q18.46: products, then differences.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pc1_q[0] <= lav_pkg::mul32(f1[1], up_q[2]);
      pc1_q[1] <= lav_pkg::mul32(f1[2], up_q[1]);
      pc1_q[2] <= lav_pkg::mul32(f1[2], up_q[0]);
      pc1_q[3] <= lav_pkg::mul32(f1[0], up_q[2]);
      pc1_q[4] <= lav_pkg::mul32(f1[0], up_q[1]);
      pc1_q[5] <= lav_pkg::mul32(f1[1], up_q[0]);
      cr2_q[0] <= pc1_q[0] - pc1_q[1];
      cr2_q[1] <= pc1_q[2] - pc1_q[3];
      cr2_q[2] <= pc1_q[4] - pc1_q[5];
    end
  end

  lav_normalize u_norm_side (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .vld_i (vc2_q),
    .c_i   (cr2_q),
    .vld_o (vn2),
    .o_o   (s2)
  );

  // Delay lines that keep f and the eye position aligned with s.
  always_ff @(posedge clk_i) begin
    if (en) begin
      fdly_q[0] <= f1;
      for (int i = 1; i < FDLY; i++) fdly_q[i] <= fdly_q[i-1];
      edly_q[0] <= eye0_q;
      for (int i = 1; i < EDLY; i++) edly_q[i] <= edly_q[i-1];
    end
  end

  // Back end: u = s x f, the dot products with eye, rounding and saturation.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sf1_q[0] <= lav_pkg::mul32(s2[1], fdly_q[FDLY-1][2]);
      sf1_q[1] <= lav_pkg::mul32(s2[2], fdly_q[FDLY-1][1]);
      sf1_q[2] <= lav_pkg::mul32(s2[2], fdly_q[FDLY-1][0]);
      sf1_q[3] <= lav_pkg::mul32(s2[0], fdly_q[FDLY-1][2]);
      sf1_q[4] <= lav_pkg::mul32(s2[0], fdly_q[FDLY-1][1]);
      sf1_q[5] <= lav_pkg::mul32(s2[1], fdly_q[FDLY-1][0]);
      for (int l = 0; l < 3; l++) begin
        se1_q[l] <= lav_pkg::mul32(s2[l], edly_q[EDLY-1][l]);
        fe1_q[l] <= lav_pkg::mul32(fdly_q[FDLY-1][l], edly_q[EDLY-1][l]);
      end
      s1_q <= s2;
      f1_q <= fdly_q[FDLY-1];
      e1_q <= edly_q[EDLY-1];

      u2_q[0] <= 32'(lav_pkg::round30(sf1_q[0] - sf1_q[1]));
      u2_q[1] <= 32'(lav_pkg::round30(sf1_q[2] - sf1_q[3]));
      u2_q[2] <= 32'(lav_pkg::round30(sf1_q[4] - sf1_q[5]));
      shx2_q  <= lav_pkg::sat32(lav_pkg::round30(-(se1_q[0] + se1_q[1] + se1_q[2])));
      shz2_q  <= lav_pkg::sat32(lav_pkg::round30(fe1_q[0] + fe1_q[1] + fe1_q[2]));
      s2_q <= s1_q;
      f2_q <= f1_q;
      e2_q <= e1_q;

      for (int l = 0; l < 3; l++) begin
        ue3_q[l] <= lav_pkg::mul32(u2_q[l], e2_q[l]);
      end
      s3_q   <= s2_q;
      f3_q   <= f2_q;
      u3_q   <= u2_q;
      shx3_q <= shx2_q;
      shz3_q <= shz2_q;

      shy4_q <= lav_pkg::sat32(lav_pkg::round30(-(ue3_q[0] + ue3_q[1] + ue3_q[2])));
      s4_q   <= s3_q;
      f4_q   <= f3_q;
      u4_q   <= u3_q;
      shx4_q <= shx3_q;
      shz4_q <= shz3_q;
    end
  end

  // Result of the last stage, fields in transfer order from the top word down.
  assign res4 = {s4_q[0], s4_q[1], s4_q[2], u4_q[0], u4_q[1], u4_q[2],
                 32'(-f4_q[0]), 32'(-f4_q[1]), 32'(-f4_q[2]),
                 shx4_q, shy4_q, shz4_q};

  // Side register: it takes the last-stage result when the receiver stalls,
  // so the stall reaches the pipeline only in the next cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else if (skid_q) begin
      if (out_o.ready) skid_q <= 1'b0;
    end else if (vp4_q && !out_o.ready) begin
      skid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_q && vp4_q && !out_o.ready) skid_data_q <= res4;
  end

  assign out_data = skid_q ? skid_data_q : res4;

  assign out_o.valid     = skid_q || vp4_q;
  assign out_o.side_x    = out_data[11];
  assign out_o.side_y    = out_data[10];
  assign out_o.side_z    = out_data[9];
  assign out_o.upright_x = out_data[8];
  assign out_o.upright_y = out_data[7];
  assign out_o.upright_z = out_data[6];
  assign out_o.back_x    = out_data[5];
  assign out_o.back_y    = out_data[4];
  assign out_o.back_z    = out_data[3];
  assign out_o.shift_x   = out_data[2];
  assign out_o.shift_y   = out_data[1];
  assign out_o.shift_z   = out_data[0];

`ifndef SYNTHESIS
  // A result that is not taken stays on the outputs unchanged.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_data))
    else $error("waiting result changed or dropped");

  // A zero forward vector forces a zero side vector.
  a_zero_fwd_zero_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.back_x == 0 && out_o.back_y == 0 && out_o.back_z == 0
    |-> out_o.side_x == 0 && out_o.side_y == 0 && out_o.side_z == 0)
    else $error("side vector nonzero for a zero forward vector");

  // A zero side vector forces zero upright vector and zero x and y translations.
  a_zero_side_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.side_x == 0 && out_o.side_y == 0 && out_o.side_z == 0
    |-> out_o.upright_x == 0 && out_o.upright_y == 0 && out_o.upright_z == 0 &&
        out_o.shift_x == 0 && out_o.shift_y == 0)
    else $error("upright or translation nonzero for a zero side vector");
`endif

endmodule
